>>> rtl/mse_pkg.sv
package mse_pkg;

    localparam logic [31:0] PC_RESET = 32'd64;

    // Primary opcodes (bits 30..26)
    localparam logic [4:0] OP_SPECIAL = 5'b00000;
    localparam logic [4:0] OP_MUL     = 5'b11100;
    localparam logic [4:0] OP_J       = 5'b00010;

    // Opcodes with the top bit set: immediate ALU and memory
    localparam logic [4:0] OPI_MUL = 5'b00001;
    localparam logic [4:0] OPI_ADD = 5'b10000;
    localparam logic [4:0] OPI_SUB = 5'b10001;
    localparam logic [4:0] OPI_AND = 5'b10010;
    localparam logic [4:0] OPI_NOR = 5'b10011;
    localparam logic [4:0] OPI_SLT = 5'b10101;
    localparam logic [4:0] OPI_LW  = 5'b00011;
    localparam logic [4:0] OPI_SW  = 5'b01011;

    // Opcodes with the top bit clear: branches
    localparam logic [4:0] OPB_BEQ  = 5'b00100;
    localparam logic [4:0] OPB_BLTZ = 5'b00001;
    localparam logic [4:0] OPB_BGTZ = 5'b00111;

    // Function codes of the special opcode
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_BREAK = 6'h0D;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_EXEC,
        PH_INDEX,
        PH_MEM
    } t_phase;

    // Everything one item decides in the execute cycle
    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        taken;
        logic        rw;
        logic [4:0]  dreg;
        logic [31:0] dval;
        logic        mw;
        logic [31:0] saddr;
        logic [31:0] sval;
        logic        is_load;
        logic        mem_we;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
    } t_exec;

    typedef struct packed {
        logic        acc;
        logic        we;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_dm_req;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        taken;
        logic        rw;
        logic [4:0]  dreg;
        logic [31:0] dval;
        logic        mw;
        logic [31:0] saddr;
        logic [31:0] sval;
    } t_result;

endpackage

>>> rtl/mse_regfile.sv
module mse_regfile
    import mse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [4:0]  i_ra,
    input  logic [4:0]  i_rb,
    input  t_rf_wr      i_wr,
    output logic [31:0] o_a,
    output logic [31:0] o_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic        r_vld_a;
    logic        r_vld_b;
    logic        r_hit_a;
    logic        r_hit_b;
    logic [31:0] r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a  <= r_mem[i_ra];
            r_rd_b  <= r_mem[i_rb];
            r_vld_a <= r_valid[i_ra];
            r_vld_b <= r_valid[i_rb];
            r_fwd   <= i_wr.data;
        end
    end

    // Valid bits stand in for the reset value of the array; hit flags
    // cover a write landing on the same edge as the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit_a <= i_wr.we && (i_wr.addr == i_ra);
                r_hit_b <= i_wr.we && (i_wr.addr == i_rb);
            end
        end
    end

    assign o_a = r_hit_a ? r_fwd : (r_vld_a ? r_rd_a : 32'd0);
    assign o_b = r_hit_b ? r_fwd : (r_vld_b ? r_rd_b : 32'd0);

endmodule

>>> rtl/mse_exec.sv
module mse_exec
    import mse_pkg::*;
(
    input  logic        i_kind,
    input  logic [31:0] i_instr,
    input  logic [31:0] i_data_addr,
    input  logic [31:0] i_data_value,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_exec       o_exec
);

    always_comb begin
        logic        top;
        logic [4:0]  op;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [5:0]  fn;
        logic [31:0] immz;
        logic [31:0] boff;
        logic [31:0] pc4;
        logic [31:0] eaddr;
        logic        cond;
        t_exec       x;

        top   = i_instr[31];
        op    = i_instr[30:26];
        rt    = i_instr[20:16];
        rd    = i_instr[15:11];
        sh    = i_instr[10:6];
        fn    = i_instr[5:0];
        immz  = {16'd0, i_instr[15:0]};
        boff  = {{14{i_instr[15]}}, i_instr[15:0], 2'b00};
        pc4   = i_pc + 32'd4;
        eaddr = i_a + immz;
        cond  = 1'b0;

        x           = '0;
        x.next_pc   = pc4;
        x.mem_addr  = eaddr;
        x.mem_wdata = i_b;

        if (i_kind) begin
            // Preload: write the word, leave the pc alone
            x.next_pc   = i_pc;
            x.mem_we    = 1'b1;
            x.mem_addr  = i_data_addr;
            x.mem_wdata = i_data_value;
        end else if (op == OP_SPECIAL) begin
            x.rw   = 1'b1;
            x.dreg = rd;
            unique case (fn)
                FN_SLL: x.dval = i_b << sh;
                FN_SRL: x.dval = i_b >> sh;
                FN_SRA: x.dval = $unsigned($signed(i_b) >>> sh);
                FN_ADD: x.dval = i_a + i_b;
                FN_SUB: x.dval = i_a - i_b;
                FN_AND: x.dval = i_a & i_b;
                FN_NOR: x.dval = ~(i_a | i_b);
                FN_SLT: x.dval = {31'd0, $signed(i_a) < $signed(i_b)};
                FN_JR: begin
                    x.rw      = 1'b0;
                    x.dreg    = '0;
                    x.next_pc = i_a;
                    x.taken   = 1'b1;
                end
                FN_BREAK: begin
                    x.rw      = 1'b0;
                    x.dreg    = '0;
                    x.next_pc = i_pc;
                    x.halted  = 1'b1;
                end
                default: begin
                    x.rw   = 1'b0;
                    x.dreg = '0;
                end
            endcase
        end else if (op == OP_MUL) begin
            x.rw   = 1'b1;
            x.dreg = rd;
            x.dval = i_a * i_b;
        end else if (op == OP_J) begin
            x.next_pc = {pc4[31:28], i_instr[25:0], 2'b00};
            x.taken   = 1'b1;
        end else if (top) begin
            x.rw   = 1'b1;
            x.dreg = rt;
            unique case (op)
                OPI_MUL: x.dval = i_a * immz;
                OPI_ADD: x.dval = i_a + immz;
                OPI_SUB: x.dval = i_a - immz;
                OPI_AND: x.dval = i_a & immz;
                OPI_NOR: x.dval = ~(i_a | immz);
                OPI_SLT: x.dval = {31'd0, $signed(i_a) < $signed(immz)};
                OPI_LW:  x.is_load = 1'b1;
                OPI_SW: begin
                    x.rw     = 1'b0;
                    x.dreg   = '0;
                    x.mw     = 1'b1;
                    x.saddr  = eaddr;
                    x.sval   = i_b;
                    x.mem_we = 1'b1;
                end
                default: begin
                    x.rw   = 1'b0;
                    x.dreg = '0;
                end
            endcase
        end else begin
            unique case (op)
                OPB_BEQ:  cond = (i_a == i_b);
                OPB_BLTZ: cond = i_a[31];
                OPB_BGTZ: cond = $signed(i_a) > $signed(32'd0);
                default:  cond = 1'b0;
            endcase
            if (cond) begin
                x.next_pc = pc4 + boff;
                x.taken   = 1'b1;
            end
        end

        o_exec = x;
    end

endmodule

>>> rtl/mse_dmem.sv
module mse_dmem
    import mse_pkg::*;
#(
    parameter int DATA_WORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dm_req     i_req,
    output logic [31:0] o_rdata,
    output logic        o_clearing
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam bit IS_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
    localparam logic [AW-1:0] LAST_IDX = AW'(DATA_WORDS - 1);

    logic [31:0]   r_mem [DATA_WORDS];
    logic [31:0]   r_rdata;
    logic          r_clr;
    logic [AW-1:0] r_clr_idx;
    logic [AW-1:0] w_idx;

    // Word index = (byte address / 4) mod DATA_WORDS
    if (IS_POW2) begin : g_mask
        assign w_idx = i_req.addr[AW+1:2];
    end else begin : g_recip
        // Exact reciprocal for 30-bit dividends; the index comes from the registered quotient in the next cycle
        localparam int SH = 30 + AW;
        localparam logic [63:0] RECIP =
            ((64'd1 << SH) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);

        logic [29:0] r_x;
        logic [29:0] r_q;
        logic [61:0] w_prod;
        logic [29:0] w_rem;

        assign w_prod = 62'(i_req.addr[31:2]) * 62'(RECIP[31:0]);

        always_ff @(posedge i_clk) begin
            r_x <= i_req.addr[31:2];
            r_q <= 30'(w_prod >> SH);
        end

        assign w_rem = r_x - 30'(r_q * 30'(DATA_WORDS));
        assign w_idx = w_rem[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.acc && i_req.we) begin
            r_mem[w_idx] <= i_req.wdata;
        end
        if (i_req.acc) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    // Sweep every word to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_clr) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clr <= 1'b0;
            end
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr;

endmodule

>>> rtl/mips_subset_instruction_executor.sv
// Channel | Direction | Handshake               | Beat contents
// in      | input     | i_in_valid / o_in_ready | i_kind, i_instr_word, i_data_addr,
//         |           |                         | i_data_value
// out     | output    | o_out_valid/i_out_ready | o_next_pc, o_halted, o_branch_taken,
//         |           |                         | o_reg_written, o_dest_reg, o_dest_value,
//         |           |                         | o_mem_written, o_store_addr, o_store_value
//
// Each beat passes the register file read (registered on the accept edge) and
// the execute phase, which ends in the data memory read on power-of-two depths;
// otherwise a word-index reduction phase (PH_INDEX) ends in that read instead.
// No new beat is taken while one is in flight; the next one is taken on the same
// edge that moves the last result from PH_MEM into the output register.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every data
// memory word, during which o_in_ready stays low.
// Stalls: a held output blocks retirement, and with it the next input beat.
module mips_subset_instruction_executor
    import mse_pkg::*;
#(
    parameter int DATA_WORDS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [31:0]        i_instr_word,
    input  logic [31:0]        i_data_addr,
    input  logic signed [31:0] i_data_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_next_pc,
    output logic               o_halted,
    output logic               o_branch_taken,
    output logic               o_reg_written,
    output logic [4:0]         o_dest_reg,
    output logic signed [31:0] o_dest_value,
    output logic               o_mem_written,
    output logic [31:0]        o_store_addr,
    output logic signed [31:0] o_store_value
);

    localparam bit IS_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [31:0] r_pc;

    // Input beat held for the execute cycle
    logic        r_kind;
    logic [31:0] r_instr;
    logic [31:0] r_daddr;
    logic [31:0] r_dvalue;

    t_exec       w_exec;
    t_exec       r_ex;
    t_result     r_res;
    logic        r_out_valid;

    logic        w_accept;
    logic        w_out_free;
    logic        w_retire;
    logic        w_dm_acc;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_dm_rdata;
    logic        w_dm_clearing;
    logic [31:0] w_wb_value;
    t_dm_req     w_dm_req;
    t_rf_wr      w_rf_wr;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_accept) begin
                    n_phase = PH_EXEC;
                end
            end
            PH_EXEC:  n_phase = IS_POW2 ? PH_MEM : PH_INDEX;
            PH_INDEX: n_phase = PH_MEM;
            PH_MEM: begin
                if (w_retire) begin
                    n_phase = w_accept ? PH_EXEC : PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Phase outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_retire   = 1'b0;
        w_dm_acc   = 1'b0;
        unique case (r_phase)
            PH_IDLE:  o_in_ready = !w_dm_clearing;
            PH_EXEC:  w_dm_acc   = IS_POW2;
            PH_INDEX: w_dm_acc   = 1'b1;
            PH_MEM: begin
                w_retire   = w_out_free;
                o_in_ready = w_out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pc        <= PC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (r_phase == PH_EXEC) begin
                r_pc <= w_exec.next_pc;
            end
            if (w_retire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture the beat, the execute outcome, the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_kind;
            r_instr  <= i_instr_word;
            r_daddr  <= i_data_addr;
            r_dvalue <= i_data_value;
        end
        if (r_phase == PH_EXEC) begin
            r_ex <= w_exec;
        end
        if (w_retire) begin
            r_res.next_pc <= r_ex.next_pc;
            r_res.halted  <= r_ex.halted;
            r_res.taken   <= r_ex.taken;
            r_res.rw      <= r_ex.rw;
            r_res.dreg    <= r_ex.dreg;
            r_res.dval    <= w_wb_value;
            r_res.mw      <= r_ex.mw;
            r_res.saddr   <= r_ex.saddr;
            r_res.sval    <= r_ex.sval;
        end
    end

    mse_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (w_accept),
        .i_ra    (i_instr_word[25:21]),
        .i_rb    (i_instr_word[20:16]),
        .i_wr    (w_rf_wr),
        .o_a     (w_a),
        .o_b     (w_b)
    );

    mse_exec u_exec (
        .i_kind       (r_kind),
        .i_instr      (r_instr),
        .i_data_addr  (r_daddr),
        .i_data_value (r_dvalue),
        .i_pc         (r_pc),
        .i_a          (w_a),
        .i_b          (w_b),
        .o_exec       (w_exec)
    );

    // Drive the memory from the live execute outcome in PH_EXEC, or from its
    // register in PH_INDEX, the word-index reduction phase
    always_comb begin
        w_dm_req.acc = w_dm_acc;
        if (r_phase == PH_EXEC) begin
            w_dm_req.we    = w_exec.mem_we;
            w_dm_req.addr  = w_exec.mem_addr;
            w_dm_req.wdata = w_exec.mem_wdata;
        end else begin
            w_dm_req.we    = r_ex.mem_we;
            w_dm_req.addr  = r_ex.mem_addr;
            w_dm_req.wdata = r_ex.mem_wdata;
        end
    end

    mse_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_dm_req),
        .o_rdata    (w_dm_rdata),
        .o_clearing (w_dm_clearing)
    );

    // Write back on retirement; loads take the memory word
    assign w_wb_value    = r_ex.is_load ? w_dm_rdata : r_ex.dval;
    assign w_rf_wr.we    = w_retire && r_ex.rw;
    assign w_rf_wr.addr  = r_ex.dreg;
    assign w_rf_wr.data  = w_wb_value;

    assign o_out_valid    = r_out_valid;
    assign o_next_pc      = r_res.next_pc;
    assign o_halted       = r_res.halted;
    assign o_branch_taken = r_res.taken;
    assign o_reg_written  = r_res.rw;
    assign o_dest_reg     = r_res.dreg;
    assign o_dest_value   = $signed(r_res.dval);
    assign o_mem_written  = r_res.mw;
    assign o_store_addr   = r_res.saddr;
    assign o_store_value  = $signed(r_res.sval);

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_phase == PH_EXEC))
        else $error("accepted beat did not enter execute");

    a_out_from_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_phase == PH_MEM))
        else $error("result appeared without retirement");

    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_halted) |-> (!o_reg_written && !o_mem_written && !o_branch_taken))
        else $error("halt result carries side effects");

    a_no_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dm_req.acc |-> !w_dm_clearing)
        else $error("data memory accessed during clearing pass");

endmodule
